// ----- sv/cti_pkg.sv -----
// Shared types and constants for the calibration table interpolator.
// No dependencies.
`timescale 1ns / 1ps
package cti_pkg;
	localparam int TablePointsDef = 128;
	localparam int IdxW = 7;
	localparam int CodeW = 15;
	localparam int AngW = 17;
	localparam int SensW = 12;
	localparam int StatW = 2;
	localparam logic [1:0] FUNC_WCODE = 2'd0;
	localparam logic [1:0] FUNC_WANGLE = 2'd1;
	localparam logic [1:0] FUNC_CONV = 2'd2;
	localparam logic [1:0] FUNC_NOP = 2'd3;
	localparam logic [StatW-1:0] ST_INSIDE = 2'd0;
	localparam logic [StatW-1:0] ST_BELOW = 2'd1;
	localparam logic [StatW-1:0] ST_ABOVE = 2'd2;
	localparam logic [AngW-1:0] ABOVE_ANGLE = 17'd68096;

	typedef struct packed {
		logic [1:0] func;
		logic direction;
		logic [IdxW-1:0] entry_index;
		logic [CodeW-1:0] table_code;
		logic [AngW-1:0] angle_entry;
		logic [SensW-1:0] sensor_code;
	} cmd_t;
endpackage

// ----- sv/cti_front.sv -----
// Front end: accepts items into a two-entry command queue; NOP items are dropped.
// Depends on cti_pkg.
`timescale 1ns / 1ps
module cti_front import cti_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  cmd_t cmd_in,
	output logic cq_valid,
	output cmd_t cq_cmd,
	input  logic cq_take
);
	cmd_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign full = (cnt_q == 2'd2);
	assign wr = push && !full && (cmd_in.func != FUNC_NOP);
	assign cq_valid = (cnt_q != 2'd0);
	assign rd = cq_valid && cq_take;
	assign cq_cmd = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= cmd_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue overflow");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |=> !$past(wr)) else $error("write while full");
	a_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> !rd) else $error("read while empty");
endmodule

// ----- sv/cti_back.sv -----
// Back end: table memories, serial scan, serial divider and result register.
// Depends on cti_pkg.
`timescale 1ns / 1ps
module cti_back import cti_pkg::*; #(
	parameter int TABLE_POINTS = TablePointsDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cq_valid,
	input  cmd_t cq_cmd,
	output logic cq_take,
	output logic empty,
	input  logic pop,
	output logic [AngW-1:0] angle,
	output logic [StatW-1:0] range_status
);
	localparam int PW = $clog2(TABLE_POINTS);
	localparam int NW = AngW + CodeW + 1;
	localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_CMP = 4'd2,
		S_A1 = 4'd3, S_A1W = 4'd4, S_A0 = 4'd5, S_A0W = 4'd6,
		S_M = 4'd7, S_DIV = 4'd8, S_OUT = 4'd9;

	logic [CodeW-1:0] ctab [2**(PW+1)];
	logic [AngW-1:0] atab [TABLE_POINTS];
	logic [3:0] st_q;
	logic [PW:0] i_q;
	logic dir_q;
	logic [CodeW-1:0] tgt_q, t0_q, t1_q, cd_q;
	logic [AngW-1:0] ad_q, a1_q, a0_q, ang_q, res_ang_q;
	logic [StatW-1:0] stat_q, res_stat_q;
	logic full_q;
	logic [NW-1:0] num_q, quo_q;
	logic [CodeW:0] rem_q;
	logic [5:0] bit_q;
	logic [PW:0] caddr;
	logic [PW-1:0] aaddr;
	logic wr_ok;
	logic [CodeW:0] rsh;
	logic [CodeW-1:0] dv;

	assign wr_ok = (int'(cq_cmd.entry_index) < TABLE_POINTS);
	assign cq_take = (st_q == S_IDLE) && cq_valid;
	assign caddr = {dir_q, i_q[PW-1:0]};
	assign aaddr = i_q[PW-1:0];
	assign dv = t1_q - t0_q;
	assign rsh = {rem_q[CodeW-1:0], num_q[NW-1]};
	assign empty = !full_q;
	assign angle = ang_q;
	assign range_status = stat_q;

	always_ff @(posedge clk) begin
		if (cq_take && wr_ok && cq_cmd.func == FUNC_WCODE)
			ctab[{cq_cmd.direction, PW'(cq_cmd.entry_index)}] <= cq_cmd.table_code;
		if (cq_take && wr_ok && cq_cmd.func == FUNC_WANGLE)
			atab[PW'(cq_cmd.entry_index)] <= cq_cmd.angle_entry;
		cd_q <= ctab[caddr];
		ad_q <= atab[aaddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			full_q <= 1'b0;
		end else begin
			if (pop && full_q) full_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (cq_take && cq_cmd.func == FUNC_CONV) begin
						dir_q <= cq_cmd.direction;
						tgt_q <= CodeW'({3'd0, cq_cmd.sensor_code} * 15'd5);
						i_q <= '0;
						st_q <= S_RD;
					end
				end
				S_RD: st_q <= S_CMP;
				S_CMP: begin
					if (tgt_q > cd_q) begin
						t0_q <= cd_q;
						if (i_q == (PW+1)'(TABLE_POINTS - 1)) begin
							res_ang_q <= ABOVE_ANGLE;
							res_stat_q <= ST_ABOVE;
							st_q <= S_OUT;
						end else begin
							i_q <= i_q + 1'b1;
							st_q <= S_RD;
						end
					end else begin
						t1_q <= cd_q;
						if (tgt_q == cd_q) begin
							res_stat_q <= ST_INSIDE;
							st_q <= S_A1;
						end else if (i_q == '0) begin
							res_ang_q <= '0;
							res_stat_q <= ST_BELOW;
							st_q <= S_OUT;
						end else begin
							res_stat_q <= ST_INSIDE;
							st_q <= S_A1;
						end
					end
				end
				S_A1: st_q <= S_A1W;
				S_A1W: begin
					a1_q <= ad_q;
					if (tgt_q == t1_q) begin
						res_ang_q <= ad_q;
						st_q <= S_OUT;
					end else begin
						i_q <= i_q - 1'b1;
						st_q <= S_A0;
					end
				end
				S_A0: st_q <= S_A0W;
				S_A0W: begin
					a0_q <= ad_q;
					st_q <= S_M;
				end
				S_M: begin
					num_q <= NW'(a0_q * (t1_q - tgt_q)) + NW'(a1_q * (tgt_q - t0_q));
					rem_q <= '0;
					bit_q <= 6'(NW);
					st_q <= S_DIV;
				end
				S_DIV: begin
					if (rsh >= {1'b0, dv}) begin
						rem_q <= rsh - {1'b0, dv};
						quo_q <= {quo_q[NW-2:0], 1'b1};
					end else begin
						rem_q <= rsh;
						quo_q <= {quo_q[NW-2:0], 1'b0};
					end
					num_q <= {num_q[NW-2:0], 1'b0};
					bit_q <= bit_q - 1'b1;
					if (bit_q == 6'd1) st_q <= S_OUT;
				end
				S_OUT: begin
					if (!full_q || pop) begin
						if (res_stat_q == ST_INSIDE && tgt_q != t1_q) begin
							ang_q <= quo_q[AngW-1:0];
						end else begin
							ang_q <= res_ang_q;
						end
						stat_q <= res_stat_q;
						full_q <= 1'b1;
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		cq_take |-> st_q == S_IDLE) else $error("take while busy");
	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_DIV |-> t1_q > t0_q) else $error("bad divisor");
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |-> (stat_q == ST_INSIDE || stat_q == ST_BELOW || stat_q == ST_ABOVE))
		else $error("bad status");
endmodule

// ----- sv/calibration_table_interpolator.sv -----
// A conversion scans the code table one entry at a time, then reads the angle entries
// and runs the bit-serial divider; a write is done when the back end takes it.
// The divider and the single-port table scan set the rate; one item at a time.
// A two-entry queue holds items during a conversion; a result waits in one output
// register while the next conversion runs.
// Reset (arst_n low, asynchronous) empties queue and result; tables keep contents.
`timescale 1ns / 1ps
module calibration_table_interpolator import cti_pkg::*; #(
	parameter int TABLE_POINTS = TablePointsDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic [1:0] func,
	input  logic direction,
	input  logic [IdxW-1:0] entry_index,
	input  logic [CodeW-1:0] table_code,
	input  logic [AngW-1:0] angle_entry,
	input  logic [SensW-1:0] sensor_code,
	output logic empty,
	input  logic pop,
	output logic [AngW-1:0] angle,
	output logic [StatW-1:0] range_status
);
	cmd_t cmd, cq_cmd;
	logic cq_valid, cq_take;

	assign cmd = '{func: func, direction: direction, entry_index: entry_index,
		table_code: table_code, angle_entry: angle_entry, sensor_code: sensor_code};

	cti_front u_front (.clk, .arst_n, .push, .full, .cmd_in(cmd),
		.cq_valid, .cq_cmd, .cq_take);

	cti_back #(.TABLE_POINTS(TABLE_POINTS)) u_back (.clk, .arst_n, .cq_valid,
		.cq_cmd, .cq_take, .empty, .pop, .angle, .range_status);
endmodule

// ----- bench/calibration_table_interpolator_test.sv -----
// Self-checking bench for calibration_table_interpolator: loads code and angle tables,
// converts sensor codes and checks each angle and range status against an in-bench table model.
// Depends on cti_pkg and the calibration_table_interpolator RTL.
`timescale 1ns / 1ps
module calibration_table_interpolator_test;
	import cti_pkg::*;

	localparam logic [1:0] FUNC_NONE = 2'd3;
	localparam int NPTS = TablePointsDef;
	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct {
		cmd_t c;
		int phase;
	} stim_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full, empty;
	logic [1:0] func = '0;
	logic direction = 1'b0;
	logic [IdxW-1:0] entry_index = '0;
	logic [CodeW-1:0] table_code = '0;
	logic [AngW-1:0] angle_entry = '0;
	logic [SensW-1:0] sensor_code = '0;
	logic [AngW-1:0] angle;
	logic [StatW-1:0] range_status;

	stim_t stim_q[$];
	logic [AngW-1:0] want_angle_q[$];
	logic [StatW-1:0] want_status_q[$];
	logic [CodeW-1:0] code_mem[2*NPTS];
	logic [AngW-1:0] angle_mem[NPTS];
	logic [CodeW-1:0] plan_code[2*NPTS];
	logic go = 1'b0;
	int cur_phase = 0;
	int mismatches = 0;
	int n_conv = 0, n_write = 0, n_below = 0, n_above = 0, n_exact = 0;
	longint cycles = 0;

	calibration_table_interpolator u_top (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void convert_code(input logic dir, input logic [SensW-1:0] x,
			output logic [AngW-1:0] ang, output logic [StatW-1:0] st);
		longint tgt, t0, t1, a0, a1, num;
		int i;
		tgt = longint'(x) * 5;
		i = 0;
		while (i < NPTS && tgt > longint'(code_mem[dir*NPTS+i]))
			i++;
		if (i >= NPTS) begin
			ang = ABOVE_ANGLE;
			st = ST_ABOVE;
			return;
		end
		t1 = code_mem[dir*NPTS+i];
		if (tgt == t1) begin
			ang = angle_mem[i];
			st = ST_INSIDE;
		end else if (i == 0) begin
			ang = '0;
			st = ST_BELOW;
		end else begin
			t0 = code_mem[dir*NPTS+i-1];
			a0 = angle_mem[i-1];
			a1 = angle_mem[i];
			num = a0 * (t1 - tgt) + a1 * (tgt - t0);
			ang = AngW'(num / (t1 - t0));
			st = ST_INSIDE;
		end
	endfunction

	task automatic apply_transfer(input cmd_t c);
		logic [AngW-1:0] a;
		logic [StatW-1:0] s;
		case (c.func)
			FUNC_WCODE: begin
				code_mem[c.direction*NPTS+c.entry_index] = c.table_code;
				n_write++;
			end
			FUNC_WANGLE: begin
				angle_mem[c.entry_index] = c.angle_entry;
				n_write++;
			end
			FUNC_CONV: begin
				convert_code(c.direction, c.sensor_code, a, s);
				want_angle_q.push_back(a);
				want_status_q.push_back(s);
				n_conv++;
				if (s == ST_BELOW) n_below++;
				if (s == ST_ABOVE) n_above++;
			end
			default: ;
		endcase
	endtask

	function automatic int send_idle_pct(input int ph);
		return (ph == 1) ? 87 : (ph == 3) ? 38 : 0;
	endfunction

	function automatic int recv_stall_pct(input int ph);
		return (ph == 2) ? 87 : (ph == 3) ? 38 : 0;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) begin
				apply_transfer(stim_q[0].c);
				stim_q.pop_front();
			end
			if (go && stim_q.size() > 0 &&
					$urandom_range(99) >= send_idle_pct(stim_q[0].phase)) begin
				push <= 1'b1;
				func <= stim_q[0].c.func;
				direction <= stim_q[0].c.direction;
				entry_index <= stim_q[0].c.entry_index;
				table_code <= stim_q[0].c.table_code;
				angle_entry <= stim_q[0].c.angle_entry;
				sensor_code <= stim_q[0].c.sensor_code;
				cur_phase <= stim_q[0].phase;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (want_angle_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected transfer: angle %0d status %0d", angle, range_status);
				end else begin
					if (angle !== want_angle_q[0] || range_status !== want_status_q[0]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: angle exp %0d got %0d, status exp %0d got %0d",
								want_angle_q[0], angle, want_status_q[0], range_status);
					end
					want_angle_q.pop_front();
					want_status_q.pop_front();
				end
			end
			pop <= ($urandom_range(99) >= recv_stall_pct(cur_phase));
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic cmd_t rand_cmd();
		cmd_t c;
		c.func = 2'($urandom_range(3));
		c.direction = 1'($urandom);
		c.entry_index = IdxW'($urandom);
		c.table_code = CodeW'($urandom);
		c.angle_entry = AngW'($urandom);
		c.sensor_code = SensW'($urandom);
		return c;
	endfunction

	task automatic add(input cmd_t c, input int ph);
		stim_t s;
		s.c = c;
		s.phase = ph;
		if (c.func == FUNC_WCODE)
			plan_code[c.direction*NPTS+c.entry_index] = c.table_code;
		stim_q.push_back(s);
	endtask

	task automatic add_code(input logic dir, input int idx, input int v, input int ph);
		cmd_t c;
		c = rand_cmd();
		c.func = FUNC_WCODE;
		c.direction = dir;
		c.entry_index = IdxW'(idx);
		c.table_code = CodeW'(v);
		add(c, ph);
	endtask

	task automatic add_angle(input int idx, input int v, input int ph);
		cmd_t c;
		c = rand_cmd();
		c.func = FUNC_WANGLE;
		c.entry_index = IdxW'(idx);
		c.angle_entry = AngW'(v);
		add(c, ph);
	endtask

	task automatic add_conv(input logic dir, input int x, input int ph);
		cmd_t c;
		c = rand_cmd();
		c.func = FUNC_CONV;
		c.direction = dir;
		c.sensor_code = SensW'(x);
		add(c, ph);
	endtask

	// ascending table, about half the points on multiples of five
	task automatic load_sorted(input logic dir, input int ph);
		int v, stp;
		v = $urandom_range(2000, 5);
		for (int i = 0; i < NPTS; i++) begin
			if (i > 0) begin
				stp = $urandom_range(240, 6);
				v = v + stp;
				if ($urandom_range(1)) v = v - v % 5;
			end
			add_code(dir, i, v, ph);
		end
	endtask

	task automatic add_random(input int ph);
		cmd_t c;
		int r, k;
		logic d;
		r = $urandom_range(99);
		d = 1'($urandom);
		k = $urandom_range(NPTS-1);
		if (r < 30) begin
			add_conv(d, plan_code[d*NPTS+k] / 5, ph);
		end else if (r < 40) begin
			add_conv(d, (plan_code[d*NPTS+k] / 5 + $urandom_range(2)) % 4096, ph);
		end else if (r < 60) begin
			add_conv(d, $urandom_range(4095), ph);
		end else if (r < 70) begin
			add_code(d, k, $urandom_range(32767), ph);
		end else if (r < 88) begin
			add_angle(k, $urandom_range(131071), ph);
		end else begin
			c = rand_cmd();
			c.func = FUNC_NONE;
			add(c, ph);
		end
	endtask

	initial begin
		for (int i = 0; i < 2*NPTS; i++) begin
			code_mem[i] = '0;
			plan_code[i] = '0;
		end
		for (int i = 0; i < NPTS; i++) angle_mem[i] = '0;

		load_sorted(1'b0, 0);
		load_sorted(1'b1, 0);
		for (int i = 0; i < NPTS; i++) add_angle(i, $urandom_range(131071), 0);

		add_conv(1'b0, 0, 0);
		add_conv(1'b1, 0, 0);
		add_conv(1'b0, 4095, 0);
		add_conv(1'b1, 4095, 0);
		add_conv(1'b0, plan_code[0] / 5, 0);
		add_conv(1'b1, plan_code[2*NPTS-1] / 5, 0);
		add_angle(0, 0, 0);
		add_angle(1, 131071, 0);
		add_angle(NPTS-1, 131071, 0);
		add_code(1'b0, 0, 5, 0);
		add_code(1'b0, 1, 32767, 0);
		add_conv(1'b0, 1, 0);
		add_conv(1'b0, 2, 0);
		add_conv(1'b0, 4095, 0);
		add_conv(1'b0, 0, 0);
		begin
			cmd_t c;
			c = rand_cmd();
			c.func = FUNC_NONE;
			add(c, 0);
		end
		add_code(1'b0, 1, 5, 0);
		add_conv(1'b0, 1, 0);
		add_code(1'b1, NPTS-1, 20475, 0);
		add_conv(1'b1, 4095, 0);

		for (int ph = 0; ph < 4; ph++) begin
			if (ph > 0) load_sorted(1'($urandom), ph);
			for (int n = 0; n < 130; n++) add_random(ph);
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		go <= 1'b1;

		wait (stim_q.size() == 0 && !push && want_angle_q.size() == 0);
		repeat (400) @(posedge clk);

		$display("covered %0d conversions (%0d below, %0d above) and %0d table writes",
			n_conv, n_below, n_above, n_write);
		$display("under four send/receive idling mixes, %0d mismatches", mismatches);
		if (mismatches == 0 && want_angle_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
